/* hw/rtl/chd_pkg.sv */
// shared types and constants for the chunked body decoder
`timescale 1ns / 1ps
`default_nettype none

package chd_pkg;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic [15:0] SIZE_WIN_RESET    = 16'd2048;
    localparam logic [15:0] TRAILER_WIN_RESET = 16'd8192;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_WIN    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRAILER_WIN = 2'd1;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_TRAILER,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // one classified request from the front to the back
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
        logic       is_hex;
        logic [3:0] hex_val;
    } chd_item_t;

    typedef struct packed {
        logic [15:0] size_win;
        logic [15:0] trailer_win;
    } chd_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/chd_front.sv */
// byte classifier feeding the request queue
`timescale 1ns / 1ps
`default_nettype none

module chd_front
    import chd_pkg::*;
(
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_data,
    input  wire logic       in_restart,
    output logic            push,
    output chd_item_t       item,
    input  wire logic       queue_ready
);

    always_comb
    begin
        item         = '0;
        item.restart = in_restart;
        item.data    = in_data;
        item.is_cr   = (in_data == CHAR_CR);
        item.is_lf   = (in_data == CHAR_LF);
        item.is_semi = (in_data == CHAR_SEMI);
        if (in_data >= 8'h30 && in_data <= 8'h39)
        begin
            item.is_hex  = 1'b1;
            item.hex_val = in_data[3:0];
        end
        else if ((in_data >= 8'h61 && in_data <= 8'h66) ||
                 (in_data >= 8'h41 && in_data <= 8'h46))
        begin
            // letters a-f and A-F share the low bits 1..6
            item.is_hex  = 1'b1;
            item.hex_val = in_data[3:0] + 4'd9;
        end
    end

    assign in_ready = queue_ready;
    assign push     = in_valid && queue_ready;

endmodule

`default_nettype wire

/* hw/rtl/chd_queue.sv */
// short request queue between classifier and parser
`timescale 1ns / 1ps
`default_nettype none

module chd_queue
    import chd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire chd_item_t  push_item,
    output logic            ready,
    input  wire logic       pop,
    output chd_item_t       pop_item,
    output logic            valid
);

    chd_item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic [QUEUE_PTR_BITS:0]   count_next;

    assign ready    = (count_reg != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> ready)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

/* hw/rtl/chd_back.sv */
// parser state machine and registered result stage
`timescale 1ns / 1ps
`default_nettype none

module chd_back
    import chd_pkg::*;
#(
    parameter int LEN_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire chd_cfg_t   cfg,
    input  wire logic       q_valid,
    input  wire chd_item_t  item,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_payload_valid,
    output logic [1:0]      out_status
);

    phase_t              phase_reg, phase_next, cur_phase;
    logic [LEN_BITS-1:0] size_reg, size_next, cur_size;
    logic [LEN_BITS-1:0] left_reg, left_next, cur_left;
    logic [15:0]         wc_reg, wc_next, cur_wc, cnt;
    logic                digit_reg, digit_next, cur_digit;
    logic                ext_reg, ext_next, cur_ext;
    logic                bad_reg, bad_next, cur_bad;
    logic [1:0]          crlf_reg, crlf_next, cur_crlf;

    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                out_pv_reg;
    logic [1:0]          out_status_reg;

    logic                lf_end, line_ok, size_over;
    logic [1:0]          tr_crlf;
    logic                tr_done, tr_bad;
    logic                res_valid;
    logic [1:0]          res_status;

    assign pop = q_valid && (!out_valid_reg || out_ready);

    // restart clears the parser ahead of this byte
    always_comb
    begin
        cur_phase = item.restart ? PH_SIZE : phase_reg;
        cur_size  = item.restart ? '0 : size_reg;
        cur_left  = item.restart ? '0 : left_reg;
        cur_wc    = item.restart ? '0 : wc_reg;
        cur_digit = item.restart ? 1'b0 : digit_reg;
        cur_ext   = item.restart ? 1'b0 : ext_reg;
        cur_bad   = item.restart ? 1'b0 : bad_reg;
        cur_crlf  = item.restart ? 2'd0 : crlf_reg;
    end

    // shared line and trailer matching
    always_comb
    begin
        cnt       = (cur_wc == 16'hFFFF) ? cur_wc : cur_wc + 16'd1;
        lf_end    = (cur_crlf == 2'd1) && item.is_lf;
        line_ok   = cur_digit && !cur_bad;
        size_over = (cnt >= cfg.size_win);
        tr_crlf   = 2'd0;
        tr_done   = 1'b0;
        if (!cur_crlf[0])
            tr_crlf = item.is_cr ? cur_crlf + 2'd1 : 2'd0;
        else if (item.is_lf)
        begin
            if (cur_crlf == 2'd3)
                tr_done = 1'b1;
            else
                tr_crlf = cur_crlf + 2'd1;
        end
        else
            tr_crlf = item.is_cr ? 2'd1 : 2'd0;
        if (cnt == 16'd2 && tr_crlf == 2'd2)
            tr_done = 1'b1;
        tr_bad = !tr_done && !(cnt == 16'd1 && item.is_cr) && (cnt >= cfg.trailer_win);
    end

    // next state
    always_comb
    begin
        phase_next = cur_phase;
        size_next  = cur_size;
        left_next  = cur_left;
        wc_next    = cur_wc;
        digit_next = cur_digit;
        ext_next   = cur_ext;
        bad_next   = cur_bad;
        crlf_next  = cur_crlf;
        unique case (cur_phase)
            PH_SIZE:
            begin
                wc_next = cnt;
                if (lf_end)
                begin
                    size_next  = '0;
                    wc_next    = '0;
                    digit_next = 1'b0;
                    ext_next   = 1'b0;
                    bad_next   = 1'b0;
                    crlf_next  = 2'd0;
                    if (!line_ok)
                        phase_next = PH_ERROR;
                    else if (cur_size == '0)
                        phase_next = PH_TRAILER;
                    else
                    begin
                        left_next  = cur_size;
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    // a lone cr outside an extension marks the line bad
                    if (cur_crlf == 2'd1 && !cur_ext)
                        bad_next = 1'b1;
                    crlf_next = 2'd0;
                    if (item.is_cr)
                        crlf_next = 2'd1;
                    else if (cur_ext)
                        ext_next = 1'b1;
                    else if (item.is_semi)
                        ext_next = 1'b1;
                    else if (!item.is_hex)
                        bad_next = 1'b1;
                    else
                    begin
                        if (cur_size[LEN_BITS-1 -: 4] != 4'd0)
                            bad_next = 1'b1;
                        size_next  = {cur_size[LEN_BITS-5:0], item.hex_val};
                        digit_next = 1'b1;
                    end
                    if (size_over)
                        phase_next = PH_ERROR;
                end
            end
            PH_DATA:
            begin
                if (cur_left != '0)
                    left_next = cur_left - 1'b1;
                if (cur_left <= LEN_BITS'(1))
                    phase_next = PH_DATA_CR;
            end
            PH_DATA_CR:
                phase_next = item.is_cr ? PH_DATA_LF : PH_ERROR;
            PH_DATA_LF:
            begin
                if (item.is_lf)
                begin
                    phase_next = PH_SIZE;
                    size_next  = '0;
                    wc_next    = '0;
                    digit_next = 1'b0;
                    ext_next   = 1'b0;
                    bad_next   = 1'b0;
                    crlf_next  = 2'd0;
                end
                else
                    phase_next = PH_ERROR;
            end
            PH_TRAILER:
            begin
                wc_next   = cnt;
                crlf_next = tr_crlf;
                if (tr_done)
                    phase_next = PH_DONE;
                else if (tr_bad)
                    phase_next = PH_ERROR;
            end
            PH_DONE:
                phase_next = PH_DONE;
            default:
                phase_next = PH_ERROR;
        endcase
    end

    // result for this byte
    always_comb
    begin
        res_valid  = 1'b0;
        res_status = ST_BUSY;
        unique case (cur_phase)
            PH_SIZE:
            begin
                if (lf_end)
                    res_status = line_ok ? ST_BUSY : ST_BAD;
                else
                    res_status = size_over ? ST_BAD : ST_BUSY;
            end
            PH_DATA:
                res_valid = 1'b1;
            PH_DATA_CR:
                res_status = item.is_cr ? ST_BUSY : ST_BAD;
            PH_DATA_LF:
                res_status = item.is_lf ? ST_BUSY : ST_BAD;
            PH_TRAILER:
                res_status = tr_done ? ST_DONE : (tr_bad ? ST_BAD : ST_BUSY);
            PH_DONE:
                res_status = ST_BUSY;
            default:
                res_status = ST_BAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            size_reg      <= '0;
            left_reg      <= '0;
            wc_reg        <= '0;
            digit_reg     <= 1'b0;
            ext_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            crlf_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                size_reg  <= size_next;
                left_reg  <= left_next;
                wc_reg    <= wc_next;
                digit_reg <= digit_next;
                ext_reg   <= ext_next;
                bad_reg   <= bad_next;
                crlf_reg  <= crlf_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg   <= res_valid ? item.data : 8'd0;
            out_pv_reg     <= res_valid;
            out_status_reg <= res_status;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign out_payload_valid = out_pv_reg;
    assign out_status        = out_status_reg;

    a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pv_reg) |-> (out_status_reg == ST_BUSY))
        else $error("payload byte carries a final status");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !item.restart && phase_reg == PH_ERROR) |=> (out_status_reg == ST_BAD))
        else $error("malformed body did not keep reporting");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !item.restart && phase_reg == PH_DONE)
        |=> (out_status_reg == ST_BUSY && !out_pv_reg))
        else $error("byte after completion not ignored");

    a_data_leaves_size: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && phase_next == PH_DATA && cur_phase == PH_SIZE) |-> (cur_size != '0))
        else $error("data phase entered with zero length");

endmodule

`default_nettype wire

/* hw/rtl/http_chunked_body_decoder.sv */
// top level of the chunked body decoder: config registers, front, queue, back
//
// channel   dir  handshake               contents
// s_axis    in   s_axis_tvalid/tready    tdata[7:0] data_byte, tuser[0] restart
// m_axis    out  m_axis_tvalid/tready    tdata[7:0] payload_byte,
//                                        tuser[0] payload_valid, tuser[2:1] status
// cfg       in   cfg_valid/cfg_ready     cfg_index 0 size_line_window, 1 trailer_window
//
// one byte per cycle while m_axis_tready stays high; a byte taken on s_axis is written
// into the queue, then popped into the registered result stage that drives m_axis
// the four-entry queue absorbs stalls so the classifier keeps taking bytes until it is full
// the parser state update on each popped byte sets the feedback loop
// reset sets the parser to expect a size line and loads the default windows
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder
    import chd_pkg::*;
#(
    parameter int LEN_BITS = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [7:0]              s_axis_tdata,   // data_byte
    input  wire logic                    s_axis_tuser,   // restart
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // payload_byte
    output logic [2:0]                   m_axis_tuser,   // payload_valid, status[1:0]
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [15:0]             cfg_data
);

    chd_cfg_t  cfg_reg;
    chd_item_t front_item, queue_item;
    logic      push, queue_ready, queue_valid, pop;
    logic      pv;
    logic [1:0] status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_win    <= SIZE_WIN_RESET;
            cfg_reg.trailer_win <= TRAILER_WIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE_WIN:    cfg_reg.size_win    <= cfg_data;
                CFG_TRAILER_WIN: cfg_reg.trailer_win <= cfg_data;
                default:         ;
            endcase
        end
    end

    chd_front u_front (
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .in_restart  (s_axis_tuser),
        .push        (push),
        .item        (front_item),
        .queue_ready (queue_ready)
    );

    chd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .ready     (queue_ready),
        .pop       (pop),
        .pop_item  (queue_item),
        .valid     (queue_valid)
    );

    chd_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .q_valid           (queue_valid),
        .item              (queue_item),
        .pop               (pop),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_byte          (m_axis_tdata),
        .out_payload_valid (pv),
        .out_status        (status)
    );

    assign m_axis_tuser = {status, pv};

endmodule

`default_nettype wire
